// ----- sv/cau_pkg.sv -----
// Shared types and codes for the complex arithmetic unit.
`timescale 1ns / 1ps
`default_nettype none

package cau_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    // mode codes on the input channel
    localparam logic [2:0] MODE_ADD = 3'd0;
    localparam logic [2:0] MODE_SUB = 3'd1;
    localparam logic [2:0] MODE_MUL = 3'd2;
    localparam logic [2:0] MODE_DIV = 3'd3;
    localparam logic [2:0] MODE_MOD = 3'd4;

    // operation after classification
    typedef enum logic [2:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV,
        OP_MOD,
        OP_NONE
    } t_op;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_DIVZ = 2'd1,
        ST_SAT  = 2'd2
    } t_status;

    // queue head towards the back end
    typedef struct packed {
        logic valid;
        t_op  op;
    } t_ctl;

    // control carried alongside the divide and root pipelines
    typedef struct packed {
        logic valid;
        t_op  op;
        logic neg_re;
        logic neg_im;
        logic sat;
        logic divz;
    } t_side;

endpackage

`default_nettype wire

// ----- sv/cau_front.sv -----
// Front end: accepts items, decodes the mode and holds them in a two-entry queue.
`timescale 1ns / 1ps
`default_nettype none

module cau_front #(
    parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_valid,
    output logic                     o_ready,
    input  wire [2:0]                i_mode,
    input  wire [4*DATA_WIDTH-1:0]   i_opnd,
    input  wire                      i_pop,
    output cau_pkg::t_ctl            o_ctl,
    output logic [4*DATA_WIDTH-1:0]  o_opnd
);

    logic [1:0]              r_count;
    logic                    r_wr_ptr;
    logic                    r_rd_ptr;
    cau_pkg::t_op            r_q_op   [0:1];
    logic [4*DATA_WIDTH-1:0] r_q_opnd [0:1];
    cau_pkg::t_op            n_op;
    logic                    n_push;
    logic                    n_pop;

    // mode decode
    always_comb begin
        case (i_mode)
            cau_pkg::MODE_ADD: n_op = cau_pkg::OP_ADD;
            cau_pkg::MODE_SUB: n_op = cau_pkg::OP_SUB;
            cau_pkg::MODE_MUL: n_op = cau_pkg::OP_MUL;
            cau_pkg::MODE_DIV: n_op = cau_pkg::OP_DIV;
            cau_pkg::MODE_MOD: n_op = cau_pkg::OP_MOD;
            default:           n_op = cau_pkg::OP_NONE;
        endcase
    end

    assign o_ready = (r_count != 2'd2);
    assign n_push  = i_valid && o_ready;
    assign n_pop   = i_pop && (r_count != 2'd0);

    // queue pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= 2'd0;
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
        end else begin
            if (n_push) r_wr_ptr <= ~r_wr_ptr;
            if (n_pop)  r_rd_ptr <= ~r_rd_ptr;
            r_count <= r_count + {1'b0, n_push} - {1'b0, n_pop};
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (n_push) begin
            r_q_op[r_wr_ptr]   <= n_op;
            r_q_opnd[r_wr_ptr] <= i_opnd;
        end
    end

    assign o_ctl.valid = (r_count != 2'd0);
    assign o_ctl.op    = r_q_op[r_rd_ptr];
    assign o_opnd      = r_q_opnd[r_rd_ptr];

endmodule

`default_nettype wire

// ----- sv/cau_div_pipe.sv -----
// Pipelined restoring divider: one quotient bit per stage, saturating overflow flag.
`timescale 1ns / 1ps
`default_nettype none

module cau_div_pipe #(
    parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = cau_pkg::FRAC_BITS_DEF
) (
    input  wire                      i_clk,
    input  wire                      i_en,
    input  wire [2*DATA_WIDTH-1:0]   i_num,
    input  wire [2*DATA_WIDTH-1:0]   i_den,
    output logic [DATA_WIDTH-1:0]    o_quo,
    output logic                     o_ovf
);

    localparam int W  = DATA_WIDTH;
    localparam int M  = 2 * DATA_WIDTH;
    localparam int HW = DATA_WIDTH + FRAC_BITS;
    localparam int CW = (HW > M) ? HW : M;

    logic [M-1:0] r_rem [0:W];
    logic [M-1:0] r_den [0:W];
    logic [W-1:0] r_lo  [0:W];
    logic [W-1:0] r_q   [0:W];
    logic         r_ovf [0:W];

    logic [M+FRAC_BITS-1:0] n_big;
    logic [CW-1:0]          n_hi_x;
    logic [CW-1:0]          n_den_x;

    // scale numerator; upper part against the divisor tells overflow
    assign n_big   = {i_num, {FRAC_BITS{1'b0}}};
    assign n_hi_x  = CW'(n_big[M+FRAC_BITS-1:W]);
    assign n_den_x = CW'(i_den);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= n_hi_x[M-1:0];
            r_den[0] <= i_den;
            r_lo[0]  <= n_big[W-1:0];
            r_q[0]   <= '0;
            r_ovf[0] <= (n_hi_x >= n_den_x);
        end
    end

    // one shift-subtract step per stage
    for (genvar k = 0; k < W; k++) begin : g_stage
        logic [M:0] n_t;
        logic [M:0] n_d;
        logic       n_ge;

        assign n_t  = {r_rem[k], r_lo[k][W-1]};
        assign n_d  = n_t - {1'b0, r_den[k]};
        assign n_ge = (n_t >= {1'b0, r_den[k]});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1] <= n_ge ? n_d[M-1:0] : n_t[M-1:0];
                r_den[k+1] <= r_den[k];
                r_lo[k+1]  <= {r_lo[k][W-2:0], 1'b0};
                r_q[k+1]   <= {r_q[k][W-2:0], n_ge};
                r_ovf[k+1] <= r_ovf[k];
            end
        end
    end

    assign o_quo = r_q[W];
    assign o_ovf = r_ovf[W];

endmodule

`default_nettype wire

// ----- sv/cau_sqrt_pipe.sv -----
// Pipelined integer square root, one root bit per stage.
`timescale 1ns / 1ps
`default_nettype none

module cau_sqrt_pipe #(
    parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF
) (
    input  wire                      i_clk,
    input  wire                      i_en,
    input  wire [2*DATA_WIDTH-1:0]   i_rad,
    output logic [DATA_WIDTH-1:0]    o_root
);

    localparam int W  = DATA_WIDTH;
    localparam int M  = 2 * DATA_WIDTH;
    localparam int RW = DATA_WIDTH + 2;

    logic [M-1:0]  r_rad  [0:W];
    logic [RW-1:0] r_rem  [0:W];
    logic [W-1:0]  r_root [0:W];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rad[0]  <= i_rad;
            r_rem[0]  <= '0;
            r_root[0] <= '0;
        end
    end

    // bring down two radicand bits, try root*4+1
    for (genvar k = 0; k < W; k++) begin : g_stage
        logic [RW+1:0] n_pre;
        logic [RW+1:0] n_trial;
        logic [RW+1:0] n_d;
        logic          n_ge;

        assign n_pre   = {r_rem[k], r_rad[k][M-1:M-2]};
        assign n_trial = (RW+2)'({r_root[k], 2'b01});
        assign n_d     = n_pre - n_trial;
        assign n_ge    = (n_pre >= n_trial);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rad[k+1]  <= {r_rad[k][M-3:0], 2'b00};
                r_rem[k+1]  <= n_ge ? n_d[RW-1:0] : n_pre[RW-1:0];
                r_root[k+1] <= {r_root[k][W-2:0], n_ge};
            end
        end
    end

    assign o_root = r_root[W];

endmodule

`default_nettype wire

// ----- sv/cau_back.sv -----
// Back end: products, sums, divide and root pipelines, saturation and output register.
`timescale 1ns / 1ps
`default_nettype none

module cau_back #(
    parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = cau_pkg::FRAC_BITS_DEF
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire cau_pkg::t_ctl       i_ctl,
    input  wire [4*DATA_WIDTH-1:0]   i_opnd,
    output logic                     o_pop,
    input  wire                      i_tready,
    output logic                     o_tvalid,
    output logic [DATA_WIDTH-1:0]    o_res_re,
    output logic [DATA_WIDTH-1:0]    o_res_im,
    output logic [1:0]               o_status
);

    localparam int W  = DATA_WIDTH;
    localparam int M  = 2 * DATA_WIDTH;
    localparam int PW = 2 * DATA_WIDTH + 1;
    localparam logic [M-1:0] LIM = M'(1) << (W - 1);

    // clamp a sign and magnitude to a W-bit word, flag in the top bit
    function automatic logic [W:0] sat_fn(input logic neg, input logic [M-1:0] mag);
        logic [M-1:0] top;
        top = neg ? LIM : (LIM - M'(1));
        if (mag > top) sat_fn = {1'b1, top[W-1:0]};
        else           sat_fn = {1'b0, neg ? (W'(0) - mag[W-1:0]) : mag[W-1:0]};
    endfunction

    logic n_en;

    logic signed [W-1:0] n_ar, n_ai, n_br, n_bi, n_x, n_y;

    cau_pkg::t_ctl        r1_ctl;
    logic [W:0]           r1_sre, r1_sim;
    logic signed [M-1:0]  r1_p_rr, r1_p_ii, r1_p_ri, r1_p_ir, r1_p_xx, r1_p_yy;
    logic [W:0]           n1_sre, n1_sim;

    cau_pkg::t_ctl        r2_ctl;
    logic [PW-1:0]        r2_re, r2_im;
    logic [M-1:0]         r2_den;
    logic [PW-1:0]        n2_re, n2_im;

    logic [PW-1:0]        n_abs_re, n_abs_im;
    logic [M-1:0]         n_sh_re, n_sh_im;
    logic [W:0]           n_d_re, n_d_im;
    cau_pkg::t_side       n_side;

    cau_pkg::t_side       r_sd   [0:W];
    logic [W-1:0]         r_sd_re [0:W];
    logic [W-1:0]         r_sd_im [0:W];

    logic [W-1:0]         n_q_re, n_q_im, n_root;
    logic                 n_ovf_re, n_ovf_im;

    logic                 r_out_valid;
    logic [W-1:0]         r_out_re, r_out_im;
    logic [1:0]           r_out_st;
    logic [W:0]           n_f_re, n_f_im;
    logic [W:0]           n_m_root;
    logic [W-1:0]         n_o_re, n_o_im;
    cau_pkg::t_status     n_o_st;

    // whole pipeline advances unless a result is waiting and i_tready is low
    assign n_en  = !r_out_valid || i_tready;
    assign o_pop = n_en && i_ctl.valid;

    assign n_ar = i_opnd[W-1:0];
    assign n_ai = i_opnd[2*W-1:W];
    assign n_br = i_opnd[3*W-1:2*W];
    assign n_bi = i_opnd[4*W-1:3*W];
    assign n_x  = (i_ctl.op == cau_pkg::OP_MOD) ? n_ar : n_br;
    assign n_y  = (i_ctl.op == cau_pkg::OP_MOD) ? n_ai : n_bi;

    // stage 1: products and plain sums
    always_comb begin
        if (i_ctl.op == cau_pkg::OP_SUB) begin
            n1_sre = {n_ar[W-1], n_ar} - {n_br[W-1], n_br};
            n1_sim = {n_ai[W-1], n_ai} - {n_bi[W-1], n_bi};
        end else begin
            n1_sre = {n_ar[W-1], n_ar} + {n_br[W-1], n_br};
            n1_sim = {n_ai[W-1], n_ai} + {n_bi[W-1], n_bi};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_ctl <= '0;
        end else if (n_en) begin
            r1_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r1_sre  <= n1_sre;
            r1_sim  <= n1_sim;
            r1_p_rr <= n_ar * n_br;
            r1_p_ii <= n_ai * n_bi;
            r1_p_ri <= n_ar * n_bi;
            r1_p_ir <= n_ai * n_br;
            r1_p_xx <= n_x * n_x;
            r1_p_yy <= n_y * n_y;
        end
    end

    // stage 2: exact real and imaginary numerators, divisor or radicand
    always_comb begin
        case (r1_ctl.op)
            cau_pkg::OP_ADD, cau_pkg::OP_SUB: begin
                n2_re = {{(PW-W-1){r1_sre[W]}}, r1_sre};
                n2_im = {{(PW-W-1){r1_sim[W]}}, r1_sim};
            end
            cau_pkg::OP_MUL: begin
                n2_re = {r1_p_rr[M-1], r1_p_rr} - {r1_p_ii[M-1], r1_p_ii};
                n2_im = {r1_p_ri[M-1], r1_p_ri} + {r1_p_ir[M-1], r1_p_ir};
            end
            cau_pkg::OP_DIV: begin
                n2_re = {r1_p_rr[M-1], r1_p_rr} + {r1_p_ii[M-1], r1_p_ii};
                n2_im = {r1_p_ir[M-1], r1_p_ir} - {r1_p_ri[M-1], r1_p_ri};
            end
            default: begin
                n2_re = '0;
                n2_im = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_ctl <= '0;
        end else if (n_en) begin
            r2_ctl <= r1_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r2_re  <= n2_re;
            r2_im  <= n2_im;
            r2_den <= $unsigned(r1_p_xx) + $unsigned(r1_p_yy);
        end
    end

    // pipeline entry: magnitudes, direct results for add, subtract and multiply
    assign n_abs_re = r2_re[PW-1] ? (PW'(0) - r2_re) : r2_re;
    assign n_abs_im = r2_im[PW-1] ? (PW'(0) - r2_im) : r2_im;
    assign n_sh_re  = (r2_ctl.op == cau_pkg::OP_MUL) ? (n_abs_re[M-1:0] >> FRAC_BITS)
                                                     : n_abs_re[M-1:0];
    assign n_sh_im  = (r2_ctl.op == cau_pkg::OP_MUL) ? (n_abs_im[M-1:0] >> FRAC_BITS)
                                                     : n_abs_im[M-1:0];
    assign n_d_re   = sat_fn(r2_re[PW-1], n_sh_re);
    assign n_d_im   = sat_fn(r2_im[PW-1], n_sh_im);

    assign n_side.valid  = r2_ctl.valid;
    assign n_side.op     = r2_ctl.op;
    assign n_side.neg_re = r2_re[PW-1];
    assign n_side.neg_im = r2_im[PW-1];
    assign n_side.sat    = n_d_re[W] || n_d_im[W];
    assign n_side.divz   = (r2_den == '0);

    cau_div_pipe #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_div_re (
        .i_clk (i_clk),
        .i_en  (n_en),
        .i_num (n_abs_re[M-1:0]),
        .i_den (r2_den),
        .o_quo (n_q_re),
        .o_ovf (n_ovf_re)
    );

    cau_div_pipe #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_div_im (
        .i_clk (i_clk),
        .i_en  (n_en),
        .i_num (n_abs_im[M-1:0]),
        .i_den (r2_den),
        .o_quo (n_q_im),
        .o_ovf (n_ovf_im)
    );

    cau_sqrt_pipe #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_sqrt (
        .i_clk  (i_clk),
        .i_en   (n_en),
        .i_rad  (r2_den),
        .o_root (n_root)
    );

    // side line, same depth as the divide and root pipelines
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= W; k++) r_sd[k] <= '0;
        end else if (n_en) begin
            r_sd[0] <= n_side;
            for (int k = 0; k < W; k++) r_sd[k+1] <= r_sd[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_sd_re[0] <= n_d_re[W-1:0];
            r_sd_im[0] <= n_d_im[W-1:0];
            for (int k = 0; k < W; k++) begin
                r_sd_re[k+1] <= r_sd_re[k];
                r_sd_im[k+1] <= r_sd_im[k];
            end
        end
    end

    // final selection and saturation
    assign n_f_re   = sat_fn(r_sd[W].neg_re, n_ovf_re ? {M{1'b1}} : M'(n_q_re));
    assign n_f_im   = sat_fn(r_sd[W].neg_im, n_ovf_im ? {M{1'b1}} : M'(n_q_im));
    assign n_m_root = sat_fn(1'b0, M'(n_root));

    always_comb begin
        n_o_re = r_sd_re[W];
        n_o_im = r_sd_im[W];
        n_o_st = r_sd[W].sat ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
        case (r_sd[W].op)
            cau_pkg::OP_DIV: begin
                if (r_sd[W].divz) begin
                    n_o_re = '0;
                    n_o_im = '0;
                    n_o_st = cau_pkg::ST_DIVZ;
                end else begin
                    n_o_re = n_f_re[W-1:0];
                    n_o_im = n_f_im[W-1:0];
                    n_o_st = (n_f_re[W] || n_f_im[W]) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
                end
            end
            cau_pkg::OP_MOD: begin
                n_o_re = n_m_root[W-1:0];
                n_o_im = '0;
                n_o_st = n_m_root[W] ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
            end
            default: begin
            end
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (n_en) begin
            r_out_valid <= r_sd[W].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_out_re <= n_o_re;
            r_out_im <= n_o_im;
            r_out_st <= n_o_st;
        end
    end

    assign o_tvalid = r_out_valid;
    assign o_res_re = r_out_re;
    assign o_res_im = r_out_im;
    assign o_status = r_out_st;

endmodule

`default_nettype wire

// ----- sv/complex_arith_unit.sv -----
// Top level of the complex arithmetic unit.
//
// Complex add, subtract, multiply, divide a/b and modulus of a on signed
// fixed-point operands (DATA_WIDTH bits, FRAC_BITS fraction bits).
// Input stream: s_axis_tdata carries a_re, a_im, b_re, b_im, s_axis_tuser the
// mode. Output stream: m_axis_tdata carries res_re, res_im, m_axis_tuser the
// status (ok, divide by zero, saturated).
// An item is taken when tvalid and tready are both high.
// Throughput: one item per cycle, sustained while m_axis_tready is high.
// Every item, whatever its mode, passes the one-bit-per-stage divide and root
// pipelines, which set the delay from acceptance to m_axis_tvalid.
// A two-entry queue decouples acceptance from the arithmetic pipeline; when
// m_axis_tready is low the whole pipeline holds, the queue fills, and
// s_axis_tready drops once two items are waiting.
// Reset clears the queue and all valid flags; no item is in flight after it.
`timescale 1ns / 1ps
`default_nettype none

module complex_arith_unit #(
    parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = cau_pkg::FRAC_BITS_DEF
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                s_axis_tvalid,
    output logic                               s_axis_tready,
    // a_re, a_im, b_re, b_im
    input  wire [((4*DATA_WIDTH+7)/8)*8-1:0]   s_axis_tdata,
    // mode
    input  wire [2:0]                          s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  wire                                m_axis_tready,
    // res_re, res_im
    output logic [((2*DATA_WIDTH+7)/8)*8-1:0]  m_axis_tdata,
    // status
    output logic [1:0]                         m_axis_tuser
);

    localparam int OUT_TDW = ((2*DATA_WIDTH+7)/8)*8;

    cau_pkg::t_ctl           w_ctl;
    logic [4*DATA_WIDTH-1:0] w_opnd;
    logic                    w_pop;
    logic [DATA_WIDTH-1:0]   w_res_re;
    logic [DATA_WIDTH-1:0]   w_res_im;

    cau_front #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_mode  (s_axis_tuser),
        .i_opnd  (s_axis_tdata[4*DATA_WIDTH-1:0]),
        .i_pop   (w_pop),
        .o_ctl   (w_ctl),
        .o_opnd  (w_opnd)
    );

    cau_back #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl),
        .i_opnd   (w_opnd),
        .o_pop    (w_pop),
        .i_tready (m_axis_tready),
        .o_tvalid (m_axis_tvalid),
        .o_res_re (w_res_re),
        .o_res_im (w_res_im),
        .o_status (m_axis_tuser)
    );

    assign m_axis_tdata = OUT_TDW'({w_res_im, w_res_re});

    // divide by zero always yields a zero result
    a_divz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == cau_pkg::ST_DIVZ) |-> (w_res_re == '0)
                                                            && (w_res_im == '0))
        else $error("divide by zero result not zero");

    // status code three is never produced
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser != 2'd3))
        else $error("undefined status code");

    // a saturated result carries a clamped, non-zero part
    a_sat_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == cau_pkg::ST_SAT) |-> (w_res_re != '0)
                                                           || (w_res_im != '0))
        else $error("saturated result with both parts zero");

endmodule

`default_nettype wire
